### rtl/olid_pkg.sv
// shared types and constants for the ordered list block
package olid_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 16;

  // command codes
  typedef enum logic [1:0] {
    MODE_INS_FRONT = 2'd0,
    MODE_INS_BACK  = 2'd1,
    MODE_DELETE    = 2'd2,
    MODE_NOP       = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e                    mode;
    logic signed [DataW-1:0]  insert_value;
    logic        [PosW-1:0]   delete_position;
  } cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0]  element_value;
    logic                     is_last;
    logic                     list_empty;
    logic                     insert_dropped;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic shift_en;
    logic emit_en;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic del_shift;
    logic shift_done;
    logic emit_done;
  } status_t;

endpackage

### rtl/olid_stream_if.sv
// valid/ready stream interface with a typed payload
interface olid_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/olid_ram.sv
// generic simple dual-port ram, one write and one registered read port
module olid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/olid_ctrl.sv
// command sequencer: idle, shift after delete, emit the list
module olid_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  output logic              cmd_ready_o,
  input  olid_pkg::status_t status_i,
  output olid_pkg::ctrl_t   ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SHIFT = 3'b010,
    S_EMIT  = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d         = state_q;
    ctrl_o          = '0;
    cmd_ready_o     = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          ctrl_o.accept = 1'b1;
          state_d       = status_i.del_shift ? S_SHIFT : S_EMIT;
        end
      end
      S_SHIFT: begin
        ctrl_o.shift_en = 1'b1;
        if (status_i.shift_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        ctrl_o.emit_en = 1'b1;
        if (status_i.emit_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/olid_dp.sv
// list datapath: circular store, shift walker, emit walker, output queue
module olid_dp #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  olid_pkg::cmd_t    cmd_i,
  input  olid_pkg::ctrl_t   ctrl_i,
  output olid_pkg::status_t status_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output olid_pkg::res_t    res_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = olid_pkg::PosW;
  localparam int unsigned DW = olid_pkg::DataW;

  // logical offset to physical address, modulo CAPACITY
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(CAPACITY)) begin
      s = s - (CW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] wr_idx_q, wr_idx_d;
  logic          vld_q, vld_d;
  logic          vld_last_q, vld_last_d;
  logic          dropped_q, dropped_d;

  olid_pkg::res_t q_data_q [2];
  logic           q_wr_q, q_rd_q;
  logic [1:0]     q_cnt_q;
  logic           push, pop;
  olid_pkg::res_t push_data;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;

  logic          full, is_ins, del_hit, del_shift;
  logic [AW-1:0] head_dec, head_inc;
  logic [2:0]    room;

  olid_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign full     = (count_q == CW'(CAPACITY));
  assign is_ins   = (cmd_i.mode == olid_pkg::MODE_INS_FRONT) ||
                    (cmd_i.mode == olid_pkg::MODE_INS_BACK);
  assign del_hit  = (cmd_i.mode == olid_pkg::MODE_DELETE) &&
                    (cmd_i.delete_position < PW'(count_q));
  assign del_shift = del_hit && (cmd_i.delete_position != '0) &&
                     ((PW+1)'(cmd_i.delete_position) + (PW+1)'(1) < (PW+1)'(count_q));
  assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
  assign head_inc = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);

  assign pop  = res_ready_i && (q_cnt_q != 2'd0);
  // queue slots left once in-flight reads land
  assign room = 3'd2 - 3'(q_cnt_q) - 3'(vld_q) + 3'(pop);

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    idx_d      = idx_q;
    wr_idx_d   = wr_idx_q;
    vld_d      = 1'b0;
    vld_last_d = 1'b0;
    dropped_d  = dropped_q;
    we         = 1'b0;
    waddr      = phys(head_q, wr_idx_q);
    wdata      = rdata;
    re         = 1'b0;
    raddr      = phys(head_q, idx_q);
    push       = 1'b0;
    push_data  = '{element_value: $signed(rdata), is_last: vld_last_q,
                   list_empty: 1'b0, insert_dropped: dropped_q};
    status_o   = '0;
    status_o.del_shift = del_shift;

    if (ctrl_i.accept) begin
      dropped_d = is_ins && full;
      idx_d     = del_shift ? CW'(cmd_i.delete_position) + CW'(1) : '0;
      wr_idx_d  = CW'(cmd_i.delete_position);
      wdata     = DW'(cmd_i.insert_value);
      if (is_ins && !full) begin
        we      = 1'b1;
        count_d = count_q + CW'(1);
        if (cmd_i.mode == olid_pkg::MODE_INS_FRONT) begin
          head_d = head_dec;
          waddr  = head_dec;
        end else begin
          waddr = phys(head_q, count_q);
        end
      end else if (del_hit && !del_shift) begin
        count_d = count_q - CW'(1);
        if (cmd_i.delete_position == '0) begin
          head_d = head_inc;
        end
      end
    end

    if (ctrl_i.shift_en) begin
      re = (idx_q < count_q);
      if (re) begin
        idx_d = idx_q + CW'(1);
      end
      vld_d = re;
      if (vld_q) begin
        we       = 1'b1;
        wr_idx_d = wr_idx_q + CW'(1);
      end
      if (vld_q && !re) begin
        status_o.shift_done = 1'b1;
        count_d             = count_q - CW'(1);
        idx_d               = '0;
      end
    end

    if (ctrl_i.emit_en) begin
      if (count_q == '0) begin
        if (room != 3'd0) begin
          push                = 1'b1;
          push_data           = '{element_value: '0, is_last: 1'b1,
                                  list_empty: 1'b1, insert_dropped: dropped_q};
          status_o.emit_done  = 1'b1;
        end
      end else begin
        re = (idx_q < count_q) && (room != 3'd0);
        if (re) begin
          idx_d = idx_q + CW'(1);
        end
        vld_d      = re;
        vld_last_d = (idx_q == count_q - CW'(1));
        if (vld_q) begin
          push               = 1'b1;
          status_o.emit_done = vld_last_q;
        end
        if (vld_q && vld_last_q) begin
          idx_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      count_q    <= '0;
      idx_q      <= '0;
      wr_idx_q   <= '0;
      vld_q      <= 1'b0;
      vld_last_q <= 1'b0;
      dropped_q  <= 1'b0;
      q_wr_q     <= 1'b0;
      q_rd_q     <= 1'b0;
      q_cnt_q    <= 2'd0;
    end else begin
      head_q     <= head_d;
      count_q    <= count_d;
      idx_q      <= idx_d;
      wr_idx_q   <= wr_idx_d;
      vld_q      <= vld_d;
      vld_last_q <= vld_last_d;
      dropped_q  <= dropped_d;
      if (push) begin
        q_wr_q <= ~q_wr_q;
      end
      if (pop) begin
        q_rd_q <= ~q_rd_q;
      end
      q_cnt_q <= q_cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_data_q[q_wr_q] <= push_data;
    end
  end

  assign res_valid_o = (q_cnt_q != 2'd0);
  assign res_o       = q_data_q[q_rd_q];

endmodule

### rtl/ordered_list_insert_delete.sv
// top level of the ordered list with insert and delete commands
//
//   channel | dir | payload                                          | transfer when
//   cmd_i   | in  | mode, insert_value, delete_position               | valid & ready
//   res_o   | out | element_value, is_last, list_empty, insert_dropped | valid & ready
//
// one command at a time: a middle delete first walks the
// tail through the store's single write port, one element per cycle,
// then the run streams out at one result per cycle while the output
// queue has room
// reset clears count and pointers only; store contents stay undefined and no clearing pass runs
// a stalled sink holds the run in a two-entry output queue; reads pause until it has room
// a new command is taken as soon as the previous run has been queued
module ordered_list_insert_delete #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  olid_stream_if.sink   cmd_i,
  olid_stream_if.source res_o
);

  olid_pkg::ctrl_t   ctrl;
  olid_pkg::status_t status;
  olid_pkg::cmd_t    cmd;
  olid_pkg::res_t    res;
  logic              cmd_ready;
  logic              res_valid;

  assign cmd = cmd_i.payload;

  // sequencer: decides when to take a command and which walk runs
  olid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_i.valid),
    .cmd_ready_o(cmd_ready),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  // datapath: circular store with head pointer, walkers and output queue
  olid_dp #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .ctrl_i     (ctrl),
    .status_o   (status),
    .res_valid_o(res_valid),
    .res_ready_i(res_o.ready),
    .res_o      (res)
  );

  assign cmd_i.ready   = cmd_ready;
  assign res_o.valid   = res_valid;
  assign res_o.payload = res;

endmodule

### rtl/olid_checker.sv
// port-level checks for the ordered list, bound to the top level
module olid_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           cmd_valid_i,
  input logic           cmd_ready_i,
  input logic           res_valid_i,
  input logic           res_ready_i,
  input olid_pkg::res_t res_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_i))
    else $error("stalled result changed");

  // an empty-list result closes its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.list_empty |-> res_i.is_last)
    else $error("empty result not marked last");

  // an empty-list result carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_i.list_empty |-> res_i.element_value == '0)
    else $error("empty result with nonzero value");

  // the block is busy the cycle after it takes a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_i && cmd_ready_i |=> !cmd_ready_i)
    else $error("command taken back to back");

endmodule

bind ordered_list_insert_delete olid_checker u_olid_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .cmd_valid_i(cmd_i.valid),
  .cmd_ready_i(cmd_i.ready),
  .res_valid_i(res_o.valid),
  .res_ready_i(res_o.ready),
  .res_i      (res_o.payload)
);

### dv/olid_list_checker.sv
// checker that predicts the list listing after each command and compares every result
module olid_list_checker
  import olid_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  logic cmd_ready_i,
  input  cmd_t cmd_i,
  input  logic res_valid_i,
  input  logic res_ready_i,
  input  res_t res_i,
  output int   fails_o,
  output int   pending_o,
  output int   results_o,
  output int   drops_o,
  output int   peak_o
);

  logic signed [DataW-1:0] list_model[$];
  res_t                    expected_elems[$];
  res_t                    want;

  task automatic report_mismatch(input string what, input longint got, input longint exp_val);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_o, what, got, exp_val);
    fails_o++;
  endtask

  // apply one command to the list copy and queue the listing it produces
  task automatic predict_listing(input cmd_t c);
    res_t r;
    logic dropped;
    dropped = 1'b0;
    case (c.mode)
      MODE_INS_FRONT, MODE_INS_BACK: begin
        if (list_model.size() >= CAPACITY) begin
          dropped = 1'b1;
        end else if (c.mode == MODE_INS_FRONT) begin
          list_model.push_front(c.insert_value);
        end else begin
          list_model.push_back(c.insert_value);
        end
      end
      MODE_DELETE: begin
        if (int'(c.delete_position) < list_model.size()) begin
          list_model.delete(int'(c.delete_position));
        end
      end
      default: ;
    endcase
    if (dropped) drops_o++;
    if (list_model.size() > peak_o) peak_o = list_model.size();
    r.insert_dropped = dropped;
    if (list_model.size() == 0) begin
      r.element_value = '0;
      r.is_last       = 1'b1;
      r.list_empty    = 1'b1;
      expected_elems.push_back(r);
    end else begin
      for (int i = 0; i < list_model.size(); i++) begin
        r.element_value = list_model[i];
        r.is_last       = (i == list_model.size() - 1);
        r.list_empty    = 1'b0;
        expected_elems.push_back(r);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_model.delete();
      expected_elems.delete();
      pending_o = 0;
    end else begin
      // a command and a result in the same cycle: the result belongs to an older command
      if (cmd_valid_i && cmd_ready_i) predict_listing(cmd_i);
      if (res_valid_i && res_ready_i) begin
        if (expected_elems.size() == 0) begin
          report_mismatch("unexpected result, element_value", res_i.element_value, 0);
        end else begin
          want = expected_elems.pop_front();
          if (res_i.element_value !== want.element_value)
            report_mismatch("element_value", res_i.element_value, want.element_value);
          if (res_i.is_last !== want.is_last)
            report_mismatch("is_last", res_i.is_last, want.is_last);
          if (res_i.list_empty !== want.list_empty)
            report_mismatch("list_empty", res_i.list_empty, want.list_empty);
          if (res_i.insert_dropped !== want.insert_dropped)
            report_mismatch("insert_dropped", res_i.insert_dropped, want.insert_dropped);
        end
        results_o++;
      end
      pending_o = expected_elems.size();
    end
  end

endmodule

### dv/tb.sv
// testbench top for the ordered list block: stimulus, receiver pacing and verdict
module tb;
  import olid_pkg::*;

  localparam int unsigned Capacity  = 64;
  localparam int unsigned ClkPeriod = 12;
  // watchdog time limit, scaled by the clock period
  localparam longint unsigned TimeLimit = 64'd2_000_000 * ClkPeriod;
  localparam int unsigned HoldCycles = 400;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        cmd_valid    = 1'b0;
  cmd_t        cmd_data     = '0;
  logic        sink_ready   = 1'b0;
  logic        holding      = 1'b0;
  logic        hold_off_go  = 1'b0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int          commands_sent = 0;

  int fails, pending, results, drops, peak;

  olid_stream_if #(.payload_t(cmd_t)) cmd_if ();
  olid_stream_if #(.payload_t(res_t)) res_if ();

  assign cmd_if.valid   = cmd_valid;
  assign cmd_if.payload = cmd_data;
  assign res_if.ready   = sink_ready;

  ordered_list_insert_delete #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  olid_list_checker #(
    .CAPACITY(Capacity)
  ) list_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cmd_valid_i(cmd_if.valid),
    .cmd_ready_i(cmd_if.ready),
    .cmd_i      (cmd_if.payload),
    .res_valid_i(res_if.valid),
    .res_ready_i(res_if.ready),
    .res_i      (res_if.payload),
    .fails_o    (fails),
    .pending_o  (pending),
    .results_o  (results),
    .drops_o    (drops),
    .peak_o     (peak)
  );

  // free-running clock
  initial begin
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // reset held low from time zero, released once
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // result side pacing: random stalls per cycle, forced low in reset and during the hold-off
  always @(posedge clk) begin
    if (!rst_n || holding) begin
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // long receiver hold-off so the output queue fills and the command side backs up
  initial begin
    wait (hold_off_go);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    holding <= 1'b0;
  end

  // watchdog
  initial begin
    #(TimeLimit);
    $display("timeout: %0d commands sent, %0d results still pending", commands_sent, pending);
    $display("TEST FAILED");
    $finish;
  end

  // offer one command, with random idle cycles before it, and wait for its transfer
  task automatic send_cmd(input mode_e m, input logic signed [DataW-1:0] v,
                          input logic [PosW-1:0] p);
    cmd_t c;
    c.mode            = m;
    c.insert_value    = v;
    c.delete_position = p;
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_data  <= c;
    do @(posedge clk); while (!cmd_if.ready);
    commands_sent++;
  endtask

  // mostly random values, with the signed extremes and zero mixed in
  function automatic logic signed [DataW-1:0] rand_value();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return $urandom;
    endcase
  endfunction

  // positions mostly near the front, sometimes anywhere in the 16-bit range
  function automatic logic [PosW-1:0] rand_position();
    int unsigned r;
    r = $urandom_range(9);
    case (r)
      0:       return 16'($urandom_range(0, 65535));
      1:       return 16'($urandom_range(0, Capacity - 1));
      2:       return '1;
      default: return 16'($urandom_range(0, 7));
    endcase
  endfunction

  // random mix of inserts, deletes and no-change commands
  task automatic send_mixed(input int n);
    int unsigned r;
    mode_e       m;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 25)      m = MODE_INS_FRONT;
      else if (r < 45) m = MODE_INS_BACK;
      else if (r < 85) m = MODE_DELETE;
      else             m = MODE_NOP;
      send_cmd(m, rand_value(), rand_position());
    end
  endtask

  // fill past capacity so inserts get dropped, then drain with in-range deletes
  task automatic fill_and_drain();
    for (int i = 0; i < Capacity + 2; i++) begin
      send_cmd($urandom_range(1) ? MODE_INS_FRONT : MODE_INS_BACK, rand_value(),
               rand_position());
    end
    // list is exactly full here, so every position below stays valid
    for (int k = 0; k < Capacity; k++) begin
      send_cmd(MODE_DELETE, rand_value(), 16'($urandom_range(0, Capacity - 1 - k)));
    end
  endtask

  initial begin
    while (!rst_n) @(posedge clk);

    // sender idles lightly, receiver heavily
    src_idle_pct = 26;
    snk_idle_pct = 78;

    // directed: empty list corners
    send_cmd(MODE_NOP, rand_value(), rand_position());
    send_cmd(MODE_DELETE, rand_value(), 16'd0);
    send_cmd(MODE_DELETE, rand_value(), 16'd1);
    send_cmd(MODE_DELETE, rand_value(), 16'hFFFF);
    // extremes of the value field, both ends of the list
    send_cmd(MODE_INS_FRONT, 32'h7FFF_FFFF, 16'hFFFF);
    send_cmd(MODE_INS_BACK, 32'h8000_0000, 16'h0000);
    send_cmd(MODE_INS_FRONT, 32'h0000_0000, 16'hAAAA);
    send_cmd(MODE_INS_BACK, 32'hFFFF_FFFF, 16'h5555);
    // deletes at and past the end are ignored
    send_cmd(MODE_DELETE, rand_value(), 16'd4);
    send_cmd(MODE_DELETE, rand_value(), 16'hFFFF);
    // middle, last and front deletes
    send_cmd(MODE_DELETE, rand_value(), 16'd1);
    send_cmd(MODE_DELETE, rand_value(), 16'd2);
    send_cmd(MODE_DELETE, rand_value(), 16'd0);
    send_cmd(MODE_NOP, rand_value(), rand_position());
    send_cmd(MODE_DELETE, rand_value(), 16'd0);
    // inserts into an empty list from either end
    send_cmd(MODE_INS_BACK, 32'sd1, rand_position());
    send_cmd(MODE_DELETE, rand_value(), 16'd0);
    send_cmd(MODE_INS_FRONT, 32'sd5, rand_position());

    // random, first pacing
    fill_and_drain();
    send_mixed(20);

    // sender idles heavily, receiver lightly
    src_idle_pct = 78;
    snk_idle_pct = 26;
    send_mixed(140);

    // no idling, with one long receiver hold-off while commands keep coming
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_off_go  = 1'b1;
    send_mixed(30);
    fill_and_drain();

    cmd_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    // let any trailing activity show up before judging
    repeat (2 * Capacity + 4) @(posedge clk);

    $display("covered %0d commands and %0d list elements, %0d inserts dropped on a full list",
             commands_sent, results, drops);
    $display("list grew to %0d of %0d entries under changing stalls on both sides",
             peak, Capacity);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
